[rtl/core/fpa_pkg.sv]
`default_nettype none
package fpa_pkg;

   // item kinds
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_TICK = 2'd0;
   localparam kind_type KIND_TAKE = 2'd1;
   localparam kind_type KIND_PUT  = 2'd2;

   // reply codes
   typedef logic [1:0] reply_type;
   localparam reply_type REPLY_GRANTED = 2'd0;
   localparam reply_type REPLY_BUSY    = 2'd1;
   localparam reply_type REPLY_ERROR   = 2'd2;

   // per resource state
   typedef logic [1:0] rstate_type;
   localparam rstate_type RES_FREE     = 2'd0;
   localparam rstate_type RES_TAKEN    = 2'd1;
   localparam rstate_type RES_RESERVED = 2'd2;

   // register indexes
   localparam logic CSR_SEATS  = 1'b0;
   localparam logic CSR_THRESH = 1'b1;

   // register reset values
   localparam int THRESH_RESET = 50;

endpackage
`default_nettype wire

[rtl/core/fork_pair_arbiter_with_aging_core.sv]
`default_nettype none
// Ring arbiter: requester r owns resource r on its left and resource r+1 on its right.
// Input channel (req_*): one transaction is a tick, a take or a put. A take whose
// requester equals its resource is a left take, any other take is a right take.
// Result channel (rsp_*): one reply per take, or per take/put with a bad index.
// Ticks, good-index puts and unused kinds give no reply and do not stall; the next
// transaction can follow right away.
// A bad index goes straight to the reply stage.
// A right take reads the resource state once.
// A left take reads both resource states and three failure stamps through one
// registered-read port per store, and one age unit (subtract and compare)
// judges the requester and each neighbor in turn; a grant passes through ST_WR2 as
// well, since the two state writes share one write port.
// The reply is registered; req_stall stays high until the reply is loaded, and
// a reply waits while rsp_stall is high and the previous reply is not taken.
// Reset (synchronous) frees all resources, clears all failures, zeroes time,
// and restores seats_in_use to MAX_SEATS and aging_threshold to 50.
// Registers are written through csr_* at byte address 4*i (8*i with a wide time).
module fork_pair_arbiter_with_aging_core
   import fpa_pkg::*;
#(
   parameter int MAX_SEATS = 16,
   parameter int TIME_BITS = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input channel
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic [1:0]                             req_kind,
   input  wire logic [$clog2(MAX_SEATS)-1:0]           req_resource_index,
   input  wire logic [$clog2(MAX_SEATS)-1:0]           req_requester_index,
   // result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [1:0]                                  rsp_reply,
   output logic [$clog2(MAX_SEATS)-1:0]                rsp_reply_to,
   // register port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [((TIME_BITS > 33) ? 4 : 3)-1:0]  csr_paddr,
   input  wire logic [((TIME_BITS > 33) ? 64 : 32)-1:0] csr_pwdata,
   output logic      [((TIME_BITS > 33) ? 64 : 32)-1:0] csr_prdata,
   output logic                                        csr_pready
);

   localparam int IDX_W  = $clog2(MAX_SEATS);
   localparam int SEAT_W = $clog2(MAX_SEATS + 1);
   localparam int THR_W  = TIME_BITS - 1;
   localparam int DATA_W = (TIME_BITS > 33) ? 64 : 32;
   localparam int ADDR_W = (TIME_BITS > 33) ? 4 : 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RT,
      ST_LT1,
      ST_LT2,
      ST_LT3,
      ST_WR2,
      ST_REPLY
   } state_type;

   state_type            state_ff, state_in;
   logic [SEAT_W-1:0]    seats_ff, seats_in;
   logic [THR_W-1:0]     thr_ff, thr_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [MAX_SEATS-1:0] pend_ff, pend_in;
   logic [MAX_SEATS-1:0] svld_ff, svld_in;
   logic [IDX_W-1:0]     res_ff, res_in;
   logic [IDX_W-1:0]     req_ff, req_in;
   logic [IDX_W-1:0]     right_ff, right_in;
   logic [IDX_W-1:0]     lnb_ff, lnb_in;
   logic [IDX_W-1:0]     tsel_ff, ssel_ff;
   logic [TIME_BITS-1:0] age_req_ff, age_req_in;
   logic                 cnt_req_ff, cnt_req_in;
   logic                 ok_ff, ok_in;
   reply_type            reply_ff, reply_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   reply_type            rsp_reply_ff, rsp_reply_in;
   logic [IDX_W-1:0]     rsp_to_ff, rsp_to_in;

   // memory ports
   logic                 s_we;
   logic [IDX_W-1:0]     s_waddr, s_raddr;
   rstate_type           s_wdata, s_rdata;
   logic                 t_we;
   logic [IDX_W-1:0]     t_waddr, t_raddr;
   logic [TIME_BITS-1:0] t_wdata, t_rdata;

   // ring bookkeeping
   logic [SEAT_W-1:0]    ring_n;
   logic [SEAT_W-1:0]    res_ext, req_ext;
   logic                 idx_bad;
   logic                 req_accept;

   // age unit
   logic [TIME_BITS-1:0] age;
   logic                 cnt, older, win, ok_now;
   rstate_type           st_rd;

   // register port
   logic                 csr_wr;
   logic                 csr_idx;

   fpa_ram #(.WIDTH($bits(rstate_type)), .DEPTH(MAX_SEATS)) u_state_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   fpa_ram #(.WIDTH(TIME_BITS), .DEPTH(MAX_SEATS)) u_stamp_ram (
      .clock   (clock),
      .wr_en   (t_we),
      .wr_addr (t_waddr),
      .wr_data (t_wdata),
      .rd_addr (t_raddr),
      .rd_data (t_rdata)
   );

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_reply    = rsp_reply_ff;
   assign rsp_reply_to = rsp_to_ff;

   // register access
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[ADDR_W-1];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      csr_prdata = '0;
      case (csr_idx)
         CSR_SEATS:  csr_prdata = DATA_W'(seats_ff);
         CSR_THRESH: csr_prdata = DATA_W'(thr_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // effective ring size and index check
   always_comb begin
      if (seats_ff < SEAT_W'(2)) begin
         ring_n = SEAT_W'(2);
      end else if (seats_ff > SEAT_W'(MAX_SEATS)) begin
         ring_n = SEAT_W'(MAX_SEATS);
      end else begin
         ring_n = seats_ff;
      end
   end

   assign res_ext = SEAT_W'(req_resource_index);
   assign req_ext = SEAT_W'(req_requester_index);
   assign idx_bad = (res_ext >= ring_n) || (req_ext >= ring_n);

   // shared age unit: judges the stamp that just came out of the stamp memory
   assign st_rd  = svld_ff[ssel_ff] ? s_rdata : RES_FREE;
   assign age    = now_ff - t_rdata;
   assign cnt    = pend_ff[tsel_ff] && (age > TIME_BITS'(thr_ff));
   assign older  = age_req_ff > age;
   assign win    = !cnt || (cnt_req_ff && older);
   assign ok_now = ok_ff && win;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      seats_in     = seats_ff;
      thr_in       = thr_ff;
      now_in       = now_ff;
      pend_in      = pend_ff;
      svld_in      = svld_ff;
      res_in       = res_ff;
      req_in       = req_ff;
      right_in     = right_ff;
      lnb_in       = lnb_ff;
      age_req_in   = age_req_ff;
      cnt_req_in   = cnt_req_ff;
      ok_in        = ok_ff;
      reply_in     = reply_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_reply_in = rsp_reply_ff;
      rsp_to_in    = rsp_to_ff;
      s_we         = 1'b0;
      s_waddr      = res_ff;
      s_wdata      = RES_TAKEN;
      s_raddr      = req_resource_index;
      t_we         = 1'b0;
      t_waddr      = req_ff;
      t_wdata      = now_ff;
      t_raddr      = req_requester_index;

      // configuration writes
      if (csr_wr) begin
         case (csr_idx)
            CSR_SEATS:  seats_in = csr_pwdata[SEAT_W-1:0];
            CSR_THRESH: thr_in   = csr_pwdata[THR_W-1:0];
            default:    ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            res_in = req_resource_index;
            req_in = req_requester_index;
            if (res_ext + SEAT_W'(1) == ring_n) begin
               right_in = '0;
            end else begin
               right_in = req_resource_index + IDX_W'(1);
            end
            if (req_requester_index == '0) begin
               lnb_in = IDX_W'(ring_n - SEAT_W'(1));
            end else begin
               lnb_in = req_requester_index - IDX_W'(1);
            end
            if (req_accept) begin
               case (req_kind)
                  KIND_TICK: now_in = now_ff + TIME_BITS'(1);
                  KIND_TAKE: begin
                     if (idx_bad) begin
                        reply_in = REPLY_ERROR;
                        state_in = ST_REPLY;
                     end else if (req_resource_index == req_requester_index) begin
                        state_in = ST_LT1;
                     end else begin
                        state_in = ST_RT;
                     end
                  end
                  KIND_PUT: begin
                     if (idx_bad) begin
                        reply_in = REPLY_ERROR;
                        state_in = ST_REPLY;
                     end else begin
                        svld_in[req_resource_index] = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // right take: claim a reserved resource
         ST_RT: begin
            if (st_rd == RES_RESERVED) begin
               s_we             = 1'b1;
               s_waddr          = res_ff;
               s_wdata          = RES_TAKEN;
               svld_in[res_ff]  = 1'b1;
               reply_in         = REPLY_GRANTED;
            end else begin
               reply_in = REPLY_ERROR;
            end
            state_in = ST_REPLY;
         end

         // left take: left state and own stamp arrive
         ST_LT1: begin
            s_raddr    = right_ff;
            t_raddr    = lnb_ff;
            age_req_in = age;
            cnt_req_in = cnt;
            ok_in      = (st_rd == RES_FREE);
            state_in   = ST_LT2;
         end

         // right state and left neighbor stamp arrive
         ST_LT2: begin
            s_raddr  = right_ff;
            t_raddr  = right_ff;
            ok_in    = ok_now && (st_rd == RES_FREE);
            state_in = ST_LT3;
         end

         // right neighbor stamp arrives, decide
         ST_LT3: begin
            if (ok_now) begin
               pend_in[req_ff] = 1'b0;
               s_we            = 1'b1;
               s_waddr         = res_ff;
               s_wdata         = RES_TAKEN;
               svld_in[res_ff] = 1'b1;
               reply_in        = REPLY_GRANTED;
               state_in        = ST_WR2;
            end else begin
               if (!pend_ff[req_ff]) begin
                  pend_in[req_ff] = 1'b1;
                  t_we            = 1'b1;
                  t_waddr         = req_ff;
                  t_wdata         = now_ff;
               end
               reply_in = REPLY_BUSY;
               state_in = ST_REPLY;
            end
         end

         // reserve the right resource
         ST_WR2: begin
            s_we              = 1'b1;
            s_waddr           = right_ff;
            s_wdata           = RES_RESERVED;
            svld_in[right_ff] = 1'b1;
            state_in          = ST_REPLY;
         end

         // hand the reply to the output register once it is free
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_reply_in = reply_ff;
               rsp_to_in    = req_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seats_ff     <= SEAT_W'(MAX_SEATS);
         thr_ff       <= THR_W'(THRESH_RESET);
         now_ff       <= '0;
         pend_ff      <= '0;
         svld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seats_ff     <= seats_in;
         thr_ff       <= thr_in;
         now_ff       <= now_in;
         pend_ff      <= pend_in;
         svld_ff      <= svld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_ff       <= res_in;
      req_ff       <= req_in;
      right_ff     <= right_in;
      lnb_ff       <= lnb_in;
      tsel_ff      <= t_raddr;
      ssel_ff      <= s_raddr;
      age_req_ff   <= age_req_in;
      cnt_req_ff   <= cnt_req_in;
      ok_ff        <= ok_in;
      reply_ff     <= reply_in;
      rsp_reply_ff <= rsp_reply_in;
      rsp_to_ff    <= rsp_to_in;
   end

endmodule
`default_nettype wire

[rtl/core/fpa_ram.sv]
`default_nettype none
module fpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/core/fpa_checker.sv]
`default_nettype none
module fpa_checker
   import fpa_pkg::*;
#(
   parameter int MAX_SEATS = 16
) (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic [1:0]                   req_kind,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [1:0]                   rsp_reply,
   input wire logic [$clog2(MAX_SEATS)-1:0] rsp_reply_to
);

   // a stalled reply holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_reply) && $stable(rsp_reply_to))
      else $error("reply changed while stalled");

   // a take keeps the block busy for its sequence
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_TAKE |=> req_stall)
      else $error("take accepted without busy period");

   // a tick leaves the block ready for the next transaction
   a_tick_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_kind == KIND_TICK |=> !req_stall)
      else $error("tick left the block busy");

   // reset leaves the block idle with no reply
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   // only defined reply codes leave the block
   a_reply_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_reply == REPLY_GRANTED || rsp_reply == REPLY_BUSY ||
                    rsp_reply == REPLY_ERROR)
      else $error("undefined reply code");

endmodule

bind fork_pair_arbiter_with_aging_core fpa_checker #(.MAX_SEATS(MAX_SEATS)) u_fpa_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_kind     (req_kind),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_reply    (rsp_reply),
   .rsp_reply_to (rsp_reply_to)
);
`default_nettype wire

[tb/tb.sv]
`default_nettype none

// one expected reply transaction
typedef struct packed {
   fpa_pkg::reply_type reply;
   logic [3:0]         reply_to;
} reply_rec_type;

// tracks resource ownership and failure aging, predicts each reply
class fork_grant_tracker;
   logic [4:0]           seats;
   logic [30:0]          threshold;
   fpa_pkg::rstate_type  fork_state [16];
   bit                   starving [16];
   logic [31:0]          first_miss [16];
   logic [31:0]          now_ticks;
   reply_rec_type        replies_due [$];
   int                   mismatches;

   function new();
      seats      = 5'd16;
      threshold  = 31'(fpa_pkg::THRESH_RESET);
      now_ticks  = '0;
      mismatches = 0;
      for (int i = 0; i < 16; i++) begin
         fork_state[i] = fpa_pkg::RES_FREE;
         starving[i]   = 1'b0;
         first_miss[i] = '0;
      end
   endfunction

   function void set_register(logic idx, logic [31:0] value);
      if (idx == fpa_pkg::CSR_SEATS) begin
         seats = value[4:0];
      end else begin
         threshold = value[30:0];
      end
   endfunction

   // ring size after clamping to the legal range
   function int unsigned ring_size();
      if (seats < 5'd2) return 2;
      if (seats > 5'd16) return 16;
      return int'(seats);
   endfunction

   function int pending();
      return replies_due.size();
   endfunction

   function logic [31:0] wait_age(int unsigned who);
      return now_ticks - first_miss[who];
   endfunction

   function bit aged(int unsigned who);
      return starving[who] && (wait_age(who) > {1'b0, threshold});
   endfunction

   // an aged neighbor outranks the requester unless the requester is aged and strictly older
   function bit yields_to(int unsigned rq, int unsigned nb);
      if (!aged(nb)) return 1'b0;
      if (!aged(rq)) return 1'b1;
      return !(wait_age(rq) > wait_age(nb));
   endfunction

   function void note_request(fpa_pkg::kind_type kind, logic [3:0] res, logic [3:0] rq);
      int unsigned   n;
      int unsigned   right;
      int unsigned   lnb;
      reply_rec_type rec;
      n = ring_size();
      // time advances, no reply
      if (kind == fpa_pkg::KIND_TICK) begin
         now_ticks = now_ticks + 32'd1;
         return;
      end
      if (kind != fpa_pkg::KIND_TAKE && kind != fpa_pkg::KIND_PUT) return;
      rec.reply_to = rq;
      if (res >= n || rq >= n) begin
         rec.reply = fpa_pkg::REPLY_ERROR;
      end else if (kind == fpa_pkg::KIND_PUT) begin
         fork_state[res] = fpa_pkg::RES_FREE;
         return;
      end else if (res == rq) begin
         // left take: both free and no neighbor with precedence
         right = (res + 1) % n;
         lnb   = (rq + n - 1) % n;
         if (fork_state[res] == fpa_pkg::RES_FREE && fork_state[right] == fpa_pkg::RES_FREE &&
             !yields_to(rq, lnb) && !yields_to(rq, right)) begin
            starving[rq]      = 1'b0;
            fork_state[res]   = fpa_pkg::RES_TAKEN;
            fork_state[right] = fpa_pkg::RES_RESERVED;
            rec.reply         = fpa_pkg::REPLY_GRANTED;
         end else begin
            if (!starving[rq]) begin
               starving[rq]   = 1'b1;
               first_miss[rq] = now_ticks;
            end
            rec.reply = fpa_pkg::REPLY_BUSY;
         end
      end else if (fork_state[res] == fpa_pkg::RES_RESERVED) begin
         // right take claims a reserved resource
         fork_state[res] = fpa_pkg::RES_TAKEN;
         rec.reply       = fpa_pkg::REPLY_GRANTED;
      end else begin
         rec.reply = fpa_pkg::REPLY_ERROR;
      end
      replies_due.insert(replies_due.size(), rec);
   endfunction

   function void check_reply(fpa_pkg::reply_type reply, logic [3:0] reply_to);
      reply_rec_type due;
      if (replies_due.size() == 0) begin
         mismatches++;
         $display("%0t: reply expected none actual %0d to %0d", $time, reply, reply_to);
         return;
      end
      due = replies_due.pop_front();
      if (due.reply != reply) begin
         mismatches++;
         $display("%0t: reply expected %0d actual %0d", $time, due.reply, reply);
      end
      if (due.reply_to != reply_to) begin
         mismatches++;
         $display("%0t: reply_to expected %0d actual %0d", $time, due.reply_to, reply_to);
      end
   endfunction
endclass

module tb;
   import fpa_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   kind_type          req_kind = KIND_TICK;
   logic [3:0]        req_resource_index = '0;
   logic [3:0]        req_requester_index = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   reply_type         rsp_reply;
   logic [3:0]        rsp_reply_to;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;
   bit                calm = 1'b0;
   fork_grant_tracker tracker;

   fork_pair_arbiter_with_aging_core DUT (.*);

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      #1000000;
      $display("Mismatches found");
      $finish;
   end

   // watch both channels at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_request(req_kind, req_resource_index, req_requester_index);
         if (rsp_valid && !rsp_stall)
            tracker.check_reply(rsp_reply, rsp_reply_to);
      end
   end

   // random backpressure on replies
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(99) < 32);
   end

   // present one transaction and hold it until accepted
   task automatic send_item(kind_type kind, logic [3:0] res, logic [3:0] rq);
      while (!calm && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_resource_index  <= res;
      req_requester_index <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop sending and wait for every outstanding reply
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      tracker.set_register(idx, value);
   endtask

   // mostly well-formed ring traffic, some noise
   task automatic random_item(int unsigned n);
      int unsigned pick;
      int unsigned who;
      pick = $urandom_range(99);
      who  = $urandom_range(n - 1);
      if (pick < 25) begin
         send_item(KIND_TICK, 4'($urandom_range(15)), 4'($urandom_range(15)));
      end else if (pick < 55) begin
         send_item(KIND_TAKE, 4'(who), 4'(who));
      end else if (pick < 70) begin
         send_item(KIND_TAKE, 4'((who + 1) % n), 4'(who));
      end else if (pick < 92) begin
         send_item(KIND_PUT, 4'($urandom_range(n - 1)), 4'(who));
      end else begin
         send_item(kind_type'($urandom_range(3)), 4'($urandom_range(15)),
                   4'($urandom_range(15)));
      end
   endtask

   task automatic run_phase(logic [4:0] seats, logic [30:0] thresh, int count, bit steady);
      drain();
      write_reg(CSR_SEATS, 32'(seats));
      write_reg(CSR_THRESH, 32'(thresh));
      calm <= steady;
      for (int i = 0; i < count; i++) random_item(tracker.ring_size());
   endtask

   // stimulus
   initial begin
      tracker = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // grants, right take errors, wraparound, unused kind
      send_item(KIND_TAKE, 4'd0, 4'd0);
      send_item(KIND_TAKE, 4'd1, 4'd0);
      send_item(KIND_TAKE, 4'd1, 4'd0);
      send_item(KIND_TAKE, 4'd1, 4'd1);
      send_item(KIND_TAKE, 4'd15, 4'd15);
      send_item(KIND_PUT, 4'd0, 4'd0);
      send_item(KIND_PUT, 4'd1, 4'd1);
      send_item(KIND_TAKE, 4'd15, 4'd15);
      send_item(KIND_TAKE, 4'd0, 4'd15);
      send_item(KIND_TAKE, 4'd5, 4'd4);
      send_item(kind_type'(2'd3), 4'd15, 4'd15);
      send_item(KIND_PUT, 4'd15, 4'd15);
      send_item(KIND_PUT, 4'd0, 4'd0);

      // small ring: bad indices and aged failures taking precedence
      drain();
      write_reg(CSR_SEATS, 32'd3);
      write_reg(CSR_THRESH, 32'd1);
      send_item(KIND_TAKE, 4'd3, 4'd0);
      send_item(KIND_TAKE, 4'd0, 4'd5);
      send_item(KIND_PUT, 4'd3, 4'd3);
      send_item(KIND_TAKE, 4'd0, 4'd0);
      send_item(KIND_TAKE, 4'd1, 4'd1);
      repeat (3) send_item(KIND_TICK, 4'd0, 4'd0);
      send_item(KIND_PUT, 4'd0, 4'd0);
      send_item(KIND_PUT, 4'd1, 4'd1);
      send_item(KIND_TAKE, 4'd0, 4'd0);
      send_item(KIND_TAKE, 4'd2, 4'd2);
      send_item(KIND_TAKE, 4'd1, 4'd1);
      send_item(KIND_PUT, 4'd1, 4'd1);
      send_item(KIND_PUT, 4'd2, 4'd2);

      // random traffic over several ring sizes and thresholds
      run_phase(5'd16, 31'd0, 140, 1'b0);
      run_phase(5'd5, 31'd3, 140, 1'b0);
      run_phase(5'd2, 31'h7FFF_FFFF, 140, 1'b1);
      run_phase(5'd0, 31'd10, 140, 1'b0);
      run_phase(5'd17, 31'd2, 140, 1'b0);
      run_phase(5'd31, 31'd1, 140, 1'b0);
      run_phase(5'd7, 31'd0, 140, 1'b0);
      run_phase(5'd3, 31'd50, 140, 1'b0);

      // final drain and verdict
      drain();
      repeat (12) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

`default_nettype wire
